// ----- design/slot_table_heap_allocator_unit_assert.svh -----
// Assertion macros used by the slot table heap allocator sequencer.
`ifndef SLOT_TABLE_HEAP_ALLOCATOR_UNIT_ASSERT_SVH
`define SLOT_TABLE_HEAP_ALLOCATOR_UNIT_ASSERT_SVH

// Checks a property at every rising clock edge outside reset.
`define STAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define STAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/stau_pkg.sv -----
// Shared types and codes of the slot table heap allocator.
`timescale 1ns / 1ps
`default_nettype none
package stau_pkg;

  localparam int GRANT_W  = 13;
  localparam int SIZE_W   = 13;
  localparam int STATUS_W = 2;
  localparam int LIVE_W   = 7;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_SLOT   = 2'd1,
    ST_HEAP_FULL = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [GRANT_W-1:0] granted;
    status_t            status;
    logic [LIVE_W-1:0]  live;
  } result_t;

endpackage
`default_nettype wire

// ----- design/slot_table_heap_allocator_unit.sv -----
// Top level of the slot table heap allocator with its result register.
//
// Usage: a request transaction on the in_ channel carries an opcode (allocate
// or free), a request size and a free address. Each request yields exactly one
// result transaction on the out_ channel with the granted address, a status
// code and the number of live blocks after the request.
// An allocate scans the slot valid bits from slot 0, one slot per cycle, until
// the first empty slot, and reports a full table when no slot is empty. A free
// scans the slot table RAM one slot per cycle until the matching slot, or
// through all slots when none matches. in_ready returns in the cycle after the
// result is handed on, so a new request is not taken before the last result
// has left the sequencer.
// Reset clears all valid bits and the live count; the slot RAM needs no clear.
// The result register holds a result until it is taken; the next request is
// accepted meanwhile and, once finished, waits in the sequencer, which keeps
// in_ready low until the result register is free.
`timescale 1ns / 1ps
`default_nettype none
module slot_table_heap_allocator_unit #(
  parameter int SLOT_COUNT   = 64,
  parameter int HEAP_BASE    = 1024,
  parameter int MEMORY_BYTES = 8192
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_opcode,
  input  wire logic [stau_pkg::SIZE_W-1:0]      in_request_size,
  input  wire logic [stau_pkg::GRANT_W-1:0]     in_free_address,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [stau_pkg::GRANT_W-1:0]     out_granted_address,
  output logic      [stau_pkg::STATUS_W-1:0]    out_status,
  output logic      [stau_pkg::LIVE_W-1:0]      out_live_blocks
);
  import stau_pkg::*;

  logic    res_valid;
  logic    res_take;
  result_t res;
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;

  stau_seq #(
    .SLOT_COUNT   (SLOT_COUNT),
    .HEAP_BASE    (HEAP_BASE),
    .MEMORY_BYTES (MEMORY_BYTES)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_request_size (in_request_size),
    .in_free_address (in_free_address),
    .res_valid       (res_valid),
    .res_take        (res_take),
    .res             (res)
  );

  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_granted_address = out_res_r.granted;
  assign out_status          = out_res_r.status;
  assign out_live_blocks     = out_res_r.live;

endmodule
`default_nettype wire

// ----- design/stau_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module stau_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

// ----- design/stau_seq.sv -----
// Slot scan sequencer with valid bits, live count and the add and compare logic.
`timescale 1ns / 1ps
`default_nettype none
`include "slot_table_heap_allocator_unit_assert.svh"
module stau_seq #(
  parameter int SLOT_COUNT   = 64,
  parameter int HEAP_BASE    = 1024,
  parameter int MEMORY_BYTES = 8192
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_opcode,
  input  wire logic [stau_pkg::SIZE_W-1:0]     in_request_size,
  input  wire logic [stau_pkg::GRANT_W-1:0]    in_free_address,
  output logic                                 res_valid,
  input  wire logic                            res_take,
  output stau_pkg::result_t                    res
);
  import stau_pkg::*;

  localparam int IDX_W     = $clog2(SLOT_COUNT);
  localparam int CW        = $clog2(SLOT_COUNT + 1);
  localparam int HEAP_SIZE = (MEMORY_BYTES > HEAP_BASE) ? MEMORY_BYTES - HEAP_BASE : 0;
  localparam int END_W     = $clog2(HEAP_SIZE + 2);
  localparam int SUM_W     = ((END_W > SIZE_W) ? END_W : SIZE_W) + 1;
  localparam int ENTRY_W   = GRANT_W + END_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ALLOC = 4'b0010,
    S_FREE  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           scan_r, scan_nxt;
  logic [SLOT_COUNT-1:0]   valid_r, valid_nxt;
  logic [CW-1:0]           live_r, live_nxt;
  result_t                 res_r, res_nxt;
  logic [SIZE_W-1:0]       size_r;
  logic [GRANT_W-1:0]      addr_r;

  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [ENTRY_W-1:0]      ram_wdata;
  logic [ENTRY_W-1:0]      ram_rdata;

  logic [IDX_W-1:0]        scan_idx;
  logic [IDX_W-1:0]        prev_idx;
  logic [GRANT_W-1:0]      rd_addr;
  logic [END_W-1:0]        rd_end;
  logic [SUM_W-1:0]        ofs;
  logic [SUM_W-1:0]        sum;
  logic                    fits;
  logic [END_W-1:0]        new_end;
  logic [GRANT_W-1:0]      new_addr;
  logic                    match;
  logic [CW-1:0]           live_inc;
  logic [CW-1:0]           live_dec;

  stau_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_idx),
    .rdata (ram_rdata)
  );

  // Once the scan has passed slot 0, the read data belongs to the slot just before the one being scanned.
  assign scan_idx = scan_r[IDX_W-1:0];
  assign prev_idx = IDX_W'(scan_r - 1'b1);
  assign rd_addr  = ram_rdata[ENTRY_W-1 -: GRANT_W];
  assign rd_end   = ram_rdata[END_W-1:0];

  assign ofs      = (scan_r == '0) ? '0 : SUM_W'(rd_end) + SUM_W'(1);
  assign sum      = ofs + SUM_W'(size_r);
  assign fits     = (size_r != '0) && (sum <= SUM_W'(HEAP_SIZE));
  assign new_end  = END_W'(sum - SUM_W'(1));
  assign new_addr = GRANT_W'(ofs + SUM_W'(HEAP_BASE));
  assign match    = valid_r[prev_idx] && (rd_addr == addr_r);
  assign live_inc = live_r + 1'b1;
  assign live_dec = (live_r != '0) ? live_r - 1'b1 : live_r;

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  always_comb begin
    state_nxt = state_r;
    scan_nxt  = scan_r;
    valid_nxt = valid_r;
    live_nxt  = live_r;
    res_nxt   = res_r;
    ram_we    = 1'b0;
    ram_waddr = scan_idx;
    ram_wdata = {new_addr, new_end};
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          scan_nxt  = '0;
          state_nxt = (in_opcode == OP_FREE) ? S_FREE : S_ALLOC;
        end
      end
      S_ALLOC: begin
        if (!valid_r[scan_idx]) begin
          if (fits) begin
            ram_we              = 1'b1;
            valid_nxt[scan_idx] = 1'b1;
            live_nxt            = live_inc;
            res_nxt.granted     = new_addr;
            res_nxt.status      = ST_OK;
            res_nxt.live        = LIVE_W'(live_inc);
          end else begin
            res_nxt.granted = '0;
            res_nxt.status  = ST_HEAP_FULL;
            res_nxt.live    = LIVE_W'(live_r);
          end
          state_nxt = S_DONE;
        end else if (scan_r == CW'(SLOT_COUNT - 1)) begin
          res_nxt.granted = '0;
          res_nxt.status  = ST_NO_SLOT;
          res_nxt.live    = LIVE_W'(live_r);
          state_nxt       = S_DONE;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_FREE: begin
        if ((scan_r != '0) && match) begin
          valid_nxt[prev_idx] = 1'b0;
          live_nxt            = live_dec;
          res_nxt.granted     = '0;
          res_nxt.status      = ST_OK;
          res_nxt.live        = LIVE_W'(live_dec);
          state_nxt           = S_DONE;
        end else if (scan_r == CW'(SLOT_COUNT)) begin
          res_nxt.granted = '0;
          res_nxt.status  = ST_NOT_FOUND;
          res_nxt.live    = LIVE_W'(live_r);
          state_nxt       = S_DONE;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      scan_r  <= '0;
      valid_r <= '0;
      live_r  <= '0;
    end else begin
      state_r <= state_nxt;
      scan_r  <= scan_nxt;
      valid_r <= valid_nxt;
      live_r  <= live_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (in_valid && in_ready) begin
      size_r <= in_request_size;
      addr_r <= in_free_address;
    end
  end

  `STAU_ASSERT(a_state_onehot, $onehot(state_r), "Sequencer state is not one-hot.")
  `STAU_ASSERT(a_live_matches_valid, $countones(valid_r) == int'(live_r), "Live count differs from valid bits.")
  `STAU_ASSERT(a_write_empty_slot, ram_we |-> !valid_r[ram_waddr], "Allocation overwrote a live slot.")
  `STAU_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state_r != S_IDLE, "Accepted transaction did not start a scan.")

endmodule
`default_nettype wire
